>>> sv/assert_macros.svh
// assertion macros shared by the sampler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is low
`define HTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never hold
`define HTS_ASSERT_NEVER(lbl, cond, msg) `HTS_ASSERT(lbl, !(cond), msg)

`endif

>>> sv/hts_pkg.sv
// shared types and constants of the heightmap triangle sampler
package hts_pkg;

    localparam int MAX_SIDE_DEF    = 256;
    localparam int HEIGHT_BITS_DEF = 24;

    // stream payload widths
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 24;
    localparam int HOUT_W    = 24;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_SPACING = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAP_COLS    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAP_ROWS    = 2'd2;

    localparam logic [23:0] INV_SPACING_RST = 24'd65536;
    localparam logic [8:0]  MAP_SIDE_RST    = 9'd256;

    // item kinds
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // shared multiplier: second operand holds the 24 bit reciprocal as signed
    localparam int MUL_B_W = 25;

    // fractions are Q0.16 with room for the value one
    localparam int FRAC_W = 17;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    localparam logic [HOUT_W-1:0] HOUT_MAX = 24'h7FFFFF;
    localparam logic [HOUT_W-1:0] HOUT_MIN = 24'h800000;

    // grid coordinate split into cell index and fraction
    typedef struct packed {
        logic              ok;
        logic [7:0]        idx;
        logic [FRAC_W-1:0] frac;
    } t_split;

    // one result transaction
    typedef struct packed {
        logic [HOUT_W-1:0] height;
        logic              outside;
        logic              was_write;
    } t_result;

endpackage

>>> sv/hts_ram.sv
// generic simple dual port ram with registered read
module hts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/hts_mul.sv
// shared signed multiplier with registered product
module hts_mul import hts_pkg::*; #(
    parameter int A_W = 33,
    parameter int B_W = MUL_B_W
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [A_W-1:0]       i_a,
    input  logic signed [B_W-1:0]       i_b,
    output logic signed [A_W+B_W-1:0]   o_p
);

    logic signed [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

>>> sv/heightmap_triangle_sampler.sv
// heightmap triangle sampler: height store, sequencer and interpolation datapath
//
// input stream s_axis carries one item per transaction; tuser[0] is the mode,
// 0 stores a height sample at (cell_row, cell_col), 1 asks for the height at
// the world position (pos_x, pos_z). output stream m_axis answers every item
// with exactly one transaction: tdata is the height, tuser flags outside and
// write acknowledge. configuration is a plain write port (i_cfg_we, i_cfg_addr,
// i_cfg_wdata), to be written by the user only while the block is idle (not enforced).
// a write passes through S_WR and S_DONE; a query runs S_MULX to S_SPLR,
// then S_DONE if it falls outside the grid, else the corner fetch and S_DIFF
// to S_RND first. s_axis_tready is high only in the idle state, so an item is
// taken only after the last one has been handed to the output register; the pace is
// set by the single shared multiplier, used four times per query, and by the one
// read port of the height ram, which fetches the four cell corners in turn.
// a finished result sits in the output register; the next item is accepted
// while it waits, and that item holds in its last state until the slot frees.
// reset (synchronous, active low) returns the sequencer to idle, drops
// m_axis_tvalid and restores the configuration defaults. the height store is
// not cleared: a sample reads as unknown until it has been written.
`include "assert_macros.svh"

module heightmap_triangle_sampler import hts_pkg::*; #(
    parameter int MAX_SIDE    = MAX_SIDE_DEF,
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pos_x[31:0], pos_z[63:32], cell_row[71:64], cell_col[79:72], height_in[103:80]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // mode[0]
    input  logic [0:0]            s_axis_tuser,
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // height_out[23:0]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // outside[0], was_write[1]
    output logic [1:0]            m_axis_tuser
);

    // memory geometry: address is row * MAX_SIDE + col
    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int AF_W   = ADDR_W + 9;
    // grid side in use is capped by the 9 bit registers and the 8 bit indexes
    localparam logic [8:0] SIDE_CAP = (MAX_SIDE < 256) ? 9'(MAX_SIDE) : 9'd256;

    // datapath widths
    localparam int DW   = HEIGHT_BITS + 1;
    localparam int MA_W = (DW > 32) ? DW : 32;
    localparam int PW   = MA_W + MUL_B_W;
    localparam int QW   = PW + 1;
    localparam int IPW  = QW - 32;
    localparam int VW   = QW - 16;

    // saturation bounds of a stored sample
    localparam logic signed [33:0] H_MAX = (34'sd1 <<< (HEIGHT_BITS - 1)) - 34'sd1;
    localparam logic signed [33:0] H_MIN = -H_MAX - 34'sd1;

    typedef enum logic [3:0] {
        S_IDLE, S_WR, S_MULX, S_MULZ, S_SPLC, S_SPLR,
        S_RD00, S_RD01, S_RD10, S_RD11, S_DIFF,
        S_MUL1, S_MUL2, S_ACC, S_RND, S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [23:0] r_inv_spacing;
    logic [8:0]  r_map_cols;
    logic [8:0]  r_map_rows;

    // item registers
    logic signed [31:0]          r_x;
    logic signed [31:0]          r_z;
    logic [7:0]                  r_row;
    logic [7:0]                  r_col;
    logic signed [23:0]          r_hin;
    logic [QW-1:0]               r_cq;
    logic [QW-1:0]               r_dq;
    logic [FRAC_W-1:0]           r_s;
    logic [FRAC_W-1:0]           r_t;
    logic                        r_okc;
    logic                        r_okr;
    logic signed [HEIGHT_BITS-1:0] r_h00;
    logic signed [HEIGHT_BITS-1:0] r_h01;
    logic signed [HEIGHT_BITS-1:0] r_h10;
    logic signed [HEIGHT_BITS-1:0] r_base;
    logic signed [DW-1:0]        r_da;
    logic signed [DW-1:0]        r_db;
    logic [FRAC_W-1:0]           r_fa;
    logic [FRAC_W-1:0]           r_fb;
    logic signed [QW-1:0]        r_acc;
    t_result                     r_res;
    t_result                     r_m_res;
    logic                        r_m_tvalid;

    // combinational
    logic [8:0]                  w_cols;
    logic [8:0]                  w_rows;
    logic                        w_out_free;
    logic                        w_wr_inside;
    logic                        w_ram_we;
    logic [ADDR_W-1:0]           w_waddr;
    logic [ADDR_W-1:0]           w_raddr;
    logic [HEIGHT_BITS-1:0]      w_wdata;
    logic [HEIGHT_BITS-1:0]      w_rdata;
    logic signed [HEIGHT_BITS-1:0] w_h11;
    logic [7:0]                  w_rd_row;
    logic [7:0]                  w_rd_col;
    logic                        w_mul_en;
    logic signed [MA_W-1:0]      w_mul_a;
    logic signed [MUL_B_W-1:0]   w_mul_b;
    logic signed [PW-1:0]        w_prod;
    logic [QW-1:0]               w_cbias;
    logic [QW-1:0]               w_rbias;
    t_split                      w_split;
    logic                        w_first;
    logic signed [QW-1:0]        w_rnd;
    logic [VW-1:0]               w_v;
    logic [HOUT_W-1:0]           w_hout;

    // clamp a grid side to the range the store supports
    function automatic logic [8:0] eff_side(input logic [8:0] v);
        logic [8:0] e;
        if (v < 9'd2) begin
            e = 9'd2;
        end else if (v > SIDE_CAP) begin
            e = SIDE_CAP;
        end else begin
            e = v;
        end
        return e;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] row,
                                                    input logic [7:0] col);
        logic [AF_W-1:0] full;
        full = AF_W'(row) * AF_W'(MAX_SIDE) + AF_W'(col);
        return full[ADDR_W-1:0];
    endfunction

    // floor and fraction of a Q.32 grid coordinate; the far edge maps onto
    // the last cell with fraction one
    function automatic t_split split_coord(input logic [QW-1:0] q, input logic [8:0] side);
        logic [IPW-1:0] ip;
        logic [31:0]    low;
        logic [IPW-1:0] side_m1;
        logic [IPW-1:0] side_m2;
        logic           far;
        t_split         res;
        ip      = q[QW-1:32];
        low     = q[31:0];
        side_m1 = IPW'(side) - IPW'(1);
        side_m2 = IPW'(side) - IPW'(2);
        far     = (ip == side_m1) && (low == 32'd0);
        res.ok   = far || (!ip[IPW-1] && (ip <= side_m2));
        res.idx  = far ? side_m2[7:0] : ip[7:0];
        res.frac = far ? FRAC_ONE : {1'b0, low[31:16]};
        return res;
    endfunction

    assign w_cols = eff_side(r_map_cols);
    assign w_rows = eff_side(r_map_rows);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_spacing <= INV_SPACING_RST;
            r_map_cols    <= MAP_SIDE_RST;
            r_map_rows    <= MAP_SIDE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_INV_SPACING: r_inv_spacing <= i_cfg_wdata;
                CFG_MAP_COLS:    r_map_cols    <= i_cfg_wdata[8:0];
                CFG_MAP_ROWS:    r_map_rows    <= i_cfg_wdata[8:0];
                default: begin
                end
            endcase
        end
    end

    // write path: saturate the sample to the store width
    assign w_wr_inside = (9'(r_row) < w_rows) && (9'(r_col) < w_cols);
    assign w_ram_we    = (r_state == S_WR) && w_wr_inside;
    assign w_waddr     = cell_addr(r_row, r_col);

    always_comb begin
        if (34'(r_hin) > H_MAX) begin
            w_wdata = H_MAX[HEIGHT_BITS-1:0];
        end else if (34'(r_hin) < H_MIN) begin
            w_wdata = H_MIN[HEIGHT_BITS-1:0];
        end else begin
            w_wdata = HEIGHT_BITS'(r_hin);
        end
    end

    // corner fetch order: h00, h01, h10, h11
    assign w_rd_row = ((r_state == S_RD10) || (r_state == S_RD11)) ? r_row + 8'd1 : r_row;
    assign w_rd_col = ((r_state == S_RD01) || (r_state == S_RD11)) ? r_col + 8'd1 : r_col;
    assign w_raddr  = cell_addr(w_rd_row, w_rd_col);

    hts_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_h11 = $signed(w_rdata);

    // operand select for the shared multiplier
    always_comb begin
        w_mul_en = 1'b0;
        w_mul_a  = MA_W'(r_x);
        w_mul_b  = $signed(MUL_B_W'(r_inv_spacing));
        unique case (r_state)
            S_MULX: begin
                w_mul_en = 1'b1;
            end
            S_MULZ: begin
                w_mul_en = 1'b1;
                w_mul_a  = MA_W'(r_z);
            end
            S_MUL1: begin
                w_mul_en = 1'b1;
                w_mul_a  = MA_W'(r_da);
                w_mul_b  = $signed(MUL_B_W'(r_fa));
            end
            S_MUL2: begin
                w_mul_en = 1'b1;
                w_mul_a  = MA_W'(r_db);
                w_mul_b  = $signed(MUL_B_W'(r_fb));
            end
            default: begin
            end
        endcase
    end

    hts_mul #(
        .A_W (MA_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // centre offsets: (side - 1) / 2 in Q.32
    assign w_cbias = QW'(w_cols - 9'd1) << 31;
    assign w_rbias = QW'(w_rows - 9'd1) << 31;

    // one splitter, columns first then rows
    assign w_split = (r_state == S_SPLC) ? split_coord(r_cq, w_cols)
                                         : split_coord(r_dq, w_rows);

    // lower triangle when s + t stays at or below one
    assign w_first = ({1'b0, r_s} + {1'b0, r_t}) <= {1'b0, FRAC_ONE};

    // round half up to signed Q24.0 and saturate
    assign w_rnd = r_acc + QW'(32768);
    assign w_v   = w_rnd[QW-1:16];
    always_comb begin
        if ((&w_v[VW-1:HOUT_W-1]) || !(|w_v[VW-1:HOUT_W-1])) begin
            w_hout = w_v[HOUT_W-1:0];
        end else if (w_v[VW-1]) begin
            w_hout = HOUT_MIN;
        end else begin
            w_hout = HOUT_MAX;
        end
    end

    assign w_out_free = !r_m_tvalid || m_axis_tready;

    // sequencer with the datapath registers and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            if (r_m_tvalid && m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_x     <= $signed(s_axis_tdata[31:0]);
                        r_z     <= $signed(s_axis_tdata[63:32]);
                        r_row   <= s_axis_tdata[71:64];
                        r_col   <= s_axis_tdata[79:72];
                        r_hin   <= $signed(s_axis_tdata[103:80]);
                        r_state <= (s_axis_tuser[0] == MODE_QUERY) ? S_MULX : S_WR;
                    end
                end
                S_WR: begin
                    r_res.height    <= '0;
                    r_res.outside   <= !w_wr_inside;
                    r_res.was_write <= 1'b1;
                    r_state         <= S_DONE;
                end
                S_MULX: begin
                    r_state <= S_MULZ;
                end
                S_MULZ: begin
                    r_cq    <= QW'(w_prod) + w_cbias;
                    r_state <= S_SPLC;
                end
                S_SPLC: begin
                    r_dq    <= w_rbias - QW'(w_prod);
                    r_col   <= w_split.idx;
                    r_s     <= w_split.frac;
                    r_okc   <= w_split.ok;
                    r_state <= S_SPLR;
                end
                S_SPLR: begin
                    r_row <= w_split.idx;
                    r_t   <= w_split.frac;
                    r_okr <= w_split.ok;
                    if (w_split.ok && r_okc) begin
                        r_state <= S_RD00;
                    end else begin
                        r_res.height    <= '0;
                        r_res.outside   <= 1'b1;
                        r_res.was_write <= 1'b0;
                        r_state         <= S_DONE;
                    end
                end
                S_RD00: begin
                    r_state <= S_RD01;
                end
                S_RD01: begin
                    r_h00   <= $signed(w_rdata);
                    r_state <= S_RD10;
                end
                S_RD10: begin
                    r_h01   <= $signed(w_rdata);
                    r_state <= S_RD11;
                end
                S_RD11: begin
                    r_h10   <= $signed(w_rdata);
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    if (w_first) begin
                        r_base <= r_h00;
                        r_da   <= DW'(r_h01) - DW'(r_h00);
                        r_db   <= DW'(r_h10) - DW'(r_h00);
                        r_fa   <= r_s;
                        r_fb   <= r_t;
                    end else begin
                        r_base <= w_h11;
                        r_da   <= DW'(r_h10) - DW'(w_h11);
                        r_db   <= DW'(r_h01) - DW'(w_h11);
                        r_fa   <= FRAC_ONE - r_s;
                        r_fb   <= FRAC_ONE - r_t;
                    end
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_acc   <= (QW'(r_base) <<< 16) + QW'(w_prod);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= r_acc + QW'(w_prod);
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_res.height    <= w_hout;
                    r_res.outside   <= 1'b0;
                    r_res.was_write <= 1'b0;
                    r_state         <= S_DONE;
                end
                S_DONE: begin
                    // hand over once the output register is free
                    if (w_out_free) begin
                        r_m_res    <= r_res;
                        r_m_tvalid <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_res.height;
    assign m_axis_tuser  = {r_m_res.was_write, r_m_res.outside};

    // store is written only for in-range cells
    `HTS_ASSERT(a_wr_in_range, w_ram_we |-> ((9'(r_row) < w_rows) && (9'(r_col) < w_cols)), "store write outside grid")
    // corner fetch runs only for points inside the grid
    `HTS_ASSERT(a_fetch_inside, (r_state == S_DIFF) |-> (r_okc && r_okr), "corner fetch for outside point")
    // a write acknowledge never carries a height
    `HTS_ASSERT(a_ack_zero, (r_m_tvalid && r_m_res.was_write) |-> (r_m_res.height == '0), "write ack with height")
    // a finished result reaches the output register once the slot frees
    `HTS_ASSERT(a_done_loads, (r_state == S_DONE && w_out_free) |=> (r_m_tvalid && (r_state == S_IDLE)), "result not delivered")

endmodule
